FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used by the block's checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BLS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/bls_pkg.sv
// ----------------------------------------------------------------------------
// Battery level smoother package
// Constants, register codes, microcode types and the control store.
// ----------------------------------------------------------------------------
`default_nettype none

package bls_pkg;

    // Fixed arithmetic shape of the gauge.
    localparam int ADC_BITS     = 12;
    localparam int SEED_SAMPLES = 8;
    localparam int FRAC_BITS    = 8;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RATIO_W    = 16;
    localparam int ALPHA_W    = 9;
    localparam int THRESH_W   = 7;
    localparam int INTERVAL_W = 16;
    localparam int PCT_W      = 7;
    localparam int TDATA_W    = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_FULL     = 3'd0,
        REG_DEFAULT_FULL = 3'd1,
        REG_EMPTY_RATIO  = 3'd2,
        REG_ALPHA        = 3'd3,
        REG_LOW_THRESH   = 3'd4,
        REG_INTERVAL     = 3'd5
    } cfg_reg_t;

    // Register reset values.
    localparam int RST_DEFAULT_FULL = 4095;
    localparam int RST_EMPTY_RATIO  = 46811;
    localparam int RST_ALPHA        = 26;
    localparam int RST_LOW_THRESH   = 20;
    localparam int RST_INTERVAL     = 1000;

    // Filter weight is Q1.8; 256 stands for one.
    localparam int ALPHA_FRAC = 8;
    localparam int ALPHA_ONE  = 1 << ALPHA_FRAC;

    // Percent values in signed fixed point.
    localparam int RAW_W       = FRAC_BITS + 11;
    localparam int RAW_LIMIT   = 1023 << FRAC_BITS;
    localparam int RAW_HALF    = 50 << FRAC_BITS;
    localparam int LEVEL_RESET = 100 << FRAC_BITS;
    localparam int PCT_MAX     = 100;
    localparam int PCT_SCALE   = 100 << FRAC_BITS;
    localparam int PCT_SCALE_W = $clog2(PCT_SCALE + 1);

    // Divider and accumulator widths.
    localparam int NUM_W      = ADC_BITS + PCT_SCALE_W;
    localparam int SEED_W     = RAW_W + $clog2(SEED_SAMPLES);
    localparam int DIV_N      = NUM_W;
    localparam int DEN_W      = ADC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_N + 1);
    localparam int SEED_CNT_W = $clog2(SEED_SAMPLES + 1);

    // Shared multiplier operand widths.
    localparam int MA_W   = (RAW_W > ADC_BITS + 1) ? RAW_W : ADC_BITS + 1;
    localparam int MB_W0  = (RATIO_W > PCT_SCALE_W) ? RATIO_W : PCT_SCALE_W;
    localparam int MB_W   = ((MB_W0 > ALPHA_W) ? MB_W0 : ALPHA_W) + 1;
    localparam int PROD_W = MA_W + MB_W;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL_EMPTY,
        OP_LOAD_EMPTY,
        OP_MUL_NUM,
        OP_DIV_RAW,
        OP_DIV_STEP,
        OP_RAW_SAT,
        OP_SEED_ACC,
        OP_SEED_SET,
        OP_MUL_KEEP,
        OP_MUL_NEW,
        OP_ACC_ADD,
        OP_IIR_SET,
        OP_DERIVE,
        OP_EMIT
    } uop_t;

    // Jump conditions; a true condition loads the target, else the step advances.
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_NO_RAW,
        C_BAD_CAL,
        C_DIV_BUSY,
        C_SEEDED,
        C_SEED_MORE,
        C_OUT_BUSY
    } ucond_t;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UPC_IDLE      = 5'd0;
    localparam upc_t UPC_MUL_EMPTY = 5'd1;
    localparam upc_t UPC_LD_EMPTY  = 5'd2;
    localparam upc_t UPC_MUL_NUM   = 5'd3;
    localparam upc_t UPC_DIV_RAW   = 5'd4;
    localparam upc_t UPC_RAW_RUN   = 5'd5;
    localparam upc_t UPC_RAW_SAT   = 5'd6;
    localparam upc_t UPC_RAW_DONE  = 5'd7;
    localparam upc_t UPC_SEED_CHK  = 5'd8;
    localparam upc_t UPC_SEED_SET  = 5'd9;
    localparam upc_t UPC_IIR_KEEP  = 5'd10;
    localparam upc_t UPC_IIR_NEW   = 5'd11;
    localparam upc_t UPC_IIR_ADD   = 5'd12;
    localparam upc_t UPC_IIR_SET   = 5'd13;
    localparam upc_t UPC_DERIVE    = 5'd14;
    localparam upc_t UPC_WAIT      = 5'd15;
    localparam upc_t UPC_EMIT      = 5'd16;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } uword_t;

    // Control store.
    function automatic uword_t ucode_rom(input upc_t upc);
        uword_t w;
        case (upc)
            UPC_IDLE:      w = '{OP_NOP,        C_NO_INPUT,  UPC_IDLE};
            UPC_MUL_EMPTY: w = '{OP_MUL_EMPTY,  C_NO_RAW,    UPC_WAIT};
            UPC_LD_EMPTY:  w = '{OP_LOAD_EMPTY, C_NEVER,     UPC_IDLE};
            UPC_MUL_NUM:   w = '{OP_MUL_NUM,    C_BAD_CAL,   UPC_RAW_DONE};
            UPC_DIV_RAW:   w = '{OP_DIV_RAW,    C_NEVER,     UPC_IDLE};
            UPC_RAW_RUN:   w = '{OP_DIV_STEP,   C_DIV_BUSY,  UPC_RAW_RUN};
            UPC_RAW_SAT:   w = '{OP_RAW_SAT,    C_NEVER,     UPC_IDLE};
            UPC_RAW_DONE:  w = '{OP_SEED_ACC,   C_SEEDED,    UPC_IIR_KEEP};
            UPC_SEED_CHK:  w = '{OP_NOP,        C_SEED_MORE, UPC_WAIT};
            UPC_SEED_SET:  w = '{OP_SEED_SET,   C_ALWAYS,    UPC_DERIVE};
            UPC_IIR_KEEP:  w = '{OP_MUL_KEEP,   C_NEVER,     UPC_IDLE};
            UPC_IIR_NEW:   w = '{OP_MUL_NEW,    C_NEVER,     UPC_IDLE};
            UPC_IIR_ADD:   w = '{OP_ACC_ADD,    C_NEVER,     UPC_IDLE};
            UPC_IIR_SET:   w = '{OP_IIR_SET,    C_NEVER,     UPC_IDLE};
            UPC_DERIVE:    w = '{OP_DERIVE,     C_NEVER,     UPC_IDLE};
            UPC_WAIT:      w = '{OP_NOP,        C_OUT_BUSY,  UPC_WAIT};
            UPC_EMIT:      w = '{OP_EMIT,       C_ALWAYS,    UPC_IDLE};
            default:       w = '{OP_NOP,        C_ALWAYS,    UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: src/battery_level_smoother_core.sv
// ----------------------------------------------------------------------------
// Battery level smoother core
// Smoothed battery gauge with seeding average, IIR filter and low flag.
// ----------------------------------------------------------------------------
// Usage
// The slave stream carries one transaction per millisecond tick: an ADC
// sample of the battery voltage and the rear button level. For each accepted
// transaction the master stream returns exactly one transaction holding the
// whole percent, the low flag, the gauge pulse and the seeding status.
// Registers are written through the plain write port while no tick is in
// flight; a write takes effect on the next clock edge.
// Timing: a microcoded sequencer runs one control word per cycle. A tick
// that needs no new reading goes straight to the output wait and emit. A
// filter update forms the reading with the 27-step restoring divider, then
// runs the filter and derives the flags; the tick that completes seeding
// sets the level from the seed average and the other seeding ticks only
// accumulate the reading. The seed average is the sum over the sample count.
// One tick is worked on at a time; the next is accepted once the sequencer
// is back at rest. Reset clears the registers to their defaults, the level
// to 100 percent and the seeding count to zero. A stalled receiver holds the
// result in the output register; the sequencer waits in front of it.
// ----------------------------------------------------------------------------
`default_nettype none

module battery_level_smoother_core
    import bls_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Slave stream: tdata = adc_sample[11:0], button_pressed[12], zero pad
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [TDATA_W-1:0]    s_axis_tdata,
    // Master stream: tdata = level_percent[6:0], battery_low[7],
    // show_gauge[8], seeding_done[9], zero pad
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [TDATA_W-1:0]         m_axis_tdata,
    // Register write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int OUT_W = PCT_W + 3;

    // Configuration registers.
    logic [ADC_BITS-1:0]   cal_full_reg,   cal_full_next;
    logic [ADC_BITS-1:0]   def_full_reg,   def_full_next;
    logic [RATIO_W-1:0]    ratio_reg,      ratio_next;
    logic [ALPHA_W-1:0]    alpha_reg,      alpha_next;
    logic [THRESH_W-1:0]   thresh_reg,     thresh_next;
    logic [INTERVAL_W-1:0] interval_reg,   interval_next;

    // Sequencer and gauge state.
    upc_t                     upc_reg,      upc_next;
    logic signed [RAW_W-1:0]  level_reg,    level_next;
    logic [PCT_W-1:0]         whole_reg,    whole_next;
    logic                     low_reg,      low_next;
    logic                     prev_btn_reg, prev_btn_next;
    logic [INTERVAL_W-1:0]    ticks_reg,    ticks_next;
    logic [SEED_CNT_W-1:0]    seed_cnt_reg, seed_cnt_next;
    logic signed [SEED_W-1:0] seed_sum_reg, seed_sum_next;
    logic                     need_raw_reg, need_raw_next;
    logic                     show_reg,     show_next;
    logic                     m_valid_reg,  m_valid_next;

    // Datapath registers.
    logic [ADC_BITS-1:0]      sample_reg,   sample_next;
    logic [ADC_BITS-1:0]      empty_reg,    empty_next;
    logic signed [PROD_W-1:0] prod_reg,     prod_next;
    logic signed [PROD_W-1:0] acc_reg,      acc_next;
    logic signed [RAW_W-1:0]  raw_reg,      raw_next;
    logic [DIV_N-1:0]         div_q_reg,    div_q_next;
    logic [DEN_W-1:0]         div_rem_reg,  div_rem_next;
    logic [DEN_W-1:0]         div_den_reg,  div_den_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg,  div_cnt_next;
    logic                     div_neg_reg,  div_neg_next;
    logic [OUT_W-1:0]         m_data_reg,   m_data_next;

    uword_t                   uw;
    logic                     cond_true;
    logic                     in_fire;
    logic                     seeded;

    logic [ADC_BITS-1:0]      full_count;
    logic                     bad_cal;
    logic [ALPHA_W-1:0]       alpha_new;
    logic [ALPHA_W-1:0]       alpha_keep;
    logic signed [ADC_BITS:0] num_diff;
    logic signed [MA_W-1:0]   mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [INTERVAL_W-1:0]    ticks_p1;

    logic [DEN_W:0]           div_trial;
    logic [DEN_W:0]           div_sub;
    logic                     div_ge;
    logic [PROD_W-1:0]        prod_mag;
    logic [RAW_W-1:0]         sat_mag;
    logic signed [RAW_W-1:0]  div_signed;
    logic signed [PROD_W-1:0] acc_adj;
    logic [RAW_W-FRAC_BITS-2:0] level_int;
    logic [PCT_W-1:0]         whole_calc;

    assign uw            = ucode_rom(upc_reg);
    assign s_axis_tready = (upc_reg == UPC_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign seeded        = (seed_cnt_reg >= SEED_CNT_W'(SEED_SAMPLES));

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = TDATA_W'(m_data_reg);

    // Calibration: fall back to the default full count when none is written.
    assign full_count = (cal_full_reg != '0) ? cal_full_reg : def_full_reg;
    assign bad_cal    = (full_count <= empty_reg);
    assign num_diff   = $signed({1'b0, sample_reg}) - $signed({1'b0, empty_reg});
    assign alpha_new  = (alpha_reg > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_reg;
    assign alpha_keep = ALPHA_W'(ALPHA_ONE) - alpha_new;
    assign ticks_p1   = ticks_reg + 1'b1;

    // Shared multiplier operand selection.
    always_comb
    begin
        case (uw.op)
            OP_MUL_EMPTY:
            begin
                mul_a = MA_W'(full_count);
                mul_b = MB_W'(ratio_reg);
            end
            OP_MUL_NUM:
            begin
                mul_a = MA_W'(num_diff);
                mul_b = MB_W'(PCT_SCALE);
            end
            OP_MUL_KEEP:
            begin
                mul_a = MA_W'(level_reg);
                mul_b = MB_W'(alpha_keep);
            end
            OP_MUL_NEW:
            begin
                mul_a = MA_W'(raw_reg);
                mul_b = MB_W'(alpha_new);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One restoring divider step on magnitudes.
    assign div_trial = {div_rem_reg, div_q_reg[DIV_N-1]};
    assign div_sub   = div_trial - {1'b0, div_den_reg};
    assign div_ge    = (div_trial >= {1'b0, div_den_reg});

    assign prod_mag = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);

    // Quotient back to signed, saturated to the reading limit.
    assign sat_mag    = (div_q_reg > DIV_N'(RAW_LIMIT)) ? RAW_W'(RAW_LIMIT)
                                                        : div_q_reg[RAW_W-1:0];
    assign div_signed = div_neg_reg ? $signed(~sat_mag + 1'b1) : $signed(sat_mag);

    // Division by the Q1.8 weight scale, truncating toward zero.
    assign acc_adj = acc_reg + (acc_reg[PROD_W-1] ? PROD_W'(ALPHA_ONE - 1) : PROD_W'(0));

    // Whole percent, clamped to the display range.
    assign level_int  = level_reg[RAW_W-2:FRAC_BITS];
    always_comb
    begin
        if (level_reg[RAW_W-1])
            whole_calc = '0;
        else if (level_int > (RAW_W-FRAC_BITS-1)'(PCT_MAX))
            whole_calc = PCT_W'(PCT_MAX);
        else
            whole_calc = level_int[PCT_W-1:0];
    end

    // Jump condition of the current control word.
    always_comb
    begin
        case (uw.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_INPUT:  cond_true = !s_axis_tvalid;
            C_NO_RAW:    cond_true = !need_raw_reg;
            C_BAD_CAL:   cond_true = bad_cal;
            C_DIV_BUSY:  cond_true = (div_cnt_reg != DIV_CNT_W'(1));
            C_SEEDED:    cond_true = seeded;
            C_SEED_MORE: cond_true = !seeded;
            C_OUT_BUSY:  cond_true = m_valid_reg && !m_axis_tready;
            default:     cond_true = 1'b0;
        endcase
    end

    // Step counter.
    always_comb
    begin
        upc_next = cond_true ? uw.target : upc_t'(upc_reg + 1'b1);
    end

    // Configuration writes.
    always_comb
    begin
        cal_full_next = cal_full_reg;
        def_full_next = def_full_reg;
        ratio_next    = ratio_reg;
        alpha_next    = alpha_reg;
        thresh_next   = thresh_reg;
        interval_next = interval_reg;
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_CAL_FULL:     cal_full_next = cfg_wdata[ADC_BITS-1:0];
                REG_DEFAULT_FULL: def_full_next = cfg_wdata[ADC_BITS-1:0];
                REG_EMPTY_RATIO:  ratio_next    = cfg_wdata[RATIO_W-1:0];
                REG_ALPHA:        alpha_next    = cfg_wdata[ALPHA_W-1:0];
                REG_LOW_THRESH:   thresh_next   = cfg_wdata[THRESH_W-1:0];
                REG_INTERVAL:     interval_next = cfg_wdata[INTERVAL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Tick bookkeeping on acceptance, then the datapath action of each step.
    always_comb
    begin
        level_next    = level_reg;
        whole_next    = whole_reg;
        low_next      = low_reg;
        prev_btn_next = prev_btn_reg;
        ticks_next    = ticks_reg;
        seed_cnt_next = seed_cnt_reg;
        seed_sum_next = seed_sum_reg;
        need_raw_next = need_raw_reg;
        show_next     = show_reg;
        m_valid_next  = m_valid_reg;
        sample_next   = sample_reg;
        empty_next    = empty_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        raw_next      = raw_reg;
        div_q_next    = div_q_reg;
        div_rem_next  = div_rem_reg;
        div_den_next  = div_den_reg;
        div_cnt_next  = div_cnt_reg;
        div_neg_next  = div_neg_reg;
        m_data_next   = m_data_reg;

        // The counter stays at zero through seeding and restarts after each update.
        if (in_fire)
        begin
            sample_next   = s_axis_tdata[ADC_BITS-1:0];
            prev_btn_next = s_axis_tdata[ADC_BITS];
            if (seeded)
            begin
                need_raw_next = (ticks_p1 >= interval_reg);
                ticks_next    = (ticks_p1 >= interval_reg) ? '0 : ticks_p1;
                show_next     = s_axis_tdata[ADC_BITS] && !prev_btn_reg;
            end
            else
            begin
                need_raw_next = 1'b1;
                show_next     = 1'b0;
            end
        end

        if (m_axis_tready)
            m_valid_next = 1'b0;

        case (uw.op)
            OP_MUL_EMPTY:  prod_next  = mul_p;
            OP_LOAD_EMPTY: empty_next = prod_reg[RATIO_W +: ADC_BITS];
            OP_MUL_NUM:
            begin
                prod_next = mul_p;
                raw_next  = RAW_W'(RAW_HALF);
            end
            OP_DIV_RAW:
            begin
                div_neg_next = prod_reg[PROD_W-1];
                div_q_next   = prod_mag[DIV_N-1:0];
                div_rem_next = '0;
                div_den_next = full_count - empty_reg;
                div_cnt_next = DIV_CNT_W'(DIV_N);
            end
            OP_DIV_STEP:
            begin
                div_rem_next = div_ge ? div_sub[DEN_W-1:0] : div_trial[DEN_W-1:0];
                div_q_next   = {div_q_reg[DIV_N-2:0], div_ge};
                div_cnt_next = div_cnt_reg - 1'b1;
            end
            OP_RAW_SAT:    raw_next = div_signed;
            OP_SEED_ACC:
            begin
                if (!seeded)
                begin
                    seed_sum_next = seed_sum_reg + SEED_W'(raw_reg);
                    seed_cnt_next = seed_cnt_reg + 1'b1;
                end
            end
            // The sample count is a power of two, so this is a biased shift.
            OP_SEED_SET:   level_next = RAW_W'(seed_sum_reg / SEED_W'(SEED_SAMPLES));
            OP_MUL_KEEP:   prod_next  = mul_p;
            OP_MUL_NEW:
            begin
                acc_next  = prod_reg;
                prod_next = mul_p;
            end
            OP_ACC_ADD:    acc_next   = acc_reg + prod_reg;
            OP_IIR_SET:    level_next = acc_adj[ALPHA_FRAC +: RAW_W];
            OP_DERIVE:
            begin
                whole_next = whole_calc;
                low_next   = (whole_calc < thresh_reg);
            end
            OP_EMIT:
            begin
                m_valid_next = 1'b1;
                m_data_next  = {seeded, show_reg, low_reg, whole_reg};
            end
            default:       ;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_full_reg <= '0;
            def_full_reg <= ADC_BITS'(RST_DEFAULT_FULL);
            ratio_reg    <= RATIO_W'(RST_EMPTY_RATIO);
            alpha_reg    <= ALPHA_W'(RST_ALPHA);
            thresh_reg   <= THRESH_W'(RST_LOW_THRESH);
            interval_reg <= INTERVAL_W'(RST_INTERVAL);
            upc_reg      <= UPC_IDLE;
            level_reg    <= RAW_W'(LEVEL_RESET);
            whole_reg    <= PCT_W'(PCT_MAX);
            low_reg      <= 1'b0;
            prev_btn_reg <= 1'b0;
            ticks_reg    <= '0;
            seed_cnt_reg <= '0;
            seed_sum_reg <= '0;
            need_raw_reg <= 1'b0;
            show_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            cal_full_reg <= cal_full_next;
            def_full_reg <= def_full_next;
            ratio_reg    <= ratio_next;
            alpha_reg    <= alpha_next;
            thresh_reg   <= thresh_next;
            interval_reg <= interval_next;
            upc_reg      <= upc_next;
            level_reg    <= level_next;
            whole_reg    <= whole_next;
            low_reg      <= low_next;
            prev_btn_reg <= prev_btn_next;
            ticks_reg    <= ticks_next;
            seed_cnt_reg <= seed_cnt_next;
            seed_sum_reg <= seed_sum_next;
            need_raw_reg <= need_raw_next;
            show_reg     <= show_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        empty_reg   <= empty_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        raw_reg     <= raw_next;
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_cnt_reg <= div_cnt_next;
        div_neg_reg <= div_neg_next;
        m_data_reg  <= m_data_next;
    end

endmodule

`default_nettype wire

FILE: src/bls_checker.sv
// ----------------------------------------------------------------------------
// Battery level smoother checker
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bls_checker
    import bls_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata
);

    // A stalled transaction keeps its contents.
    `BLS_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // The gauge never reports above full.
    `BLS_ASSERT_NOW(a_pct_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[PCT_W-1:0] <= 7'd100)

    // The gauge pulse only follows a completed seed.
    `BLS_ASSERT_NOW(a_show_seeded, clk, rst_n, m_axis_tvalid && m_axis_tdata[PCT_W+1], m_axis_tdata[PCT_W+2])

    // Until seeded the reported level stays at its reset value.
    `BLS_ASSERT_NOW(a_unseeded, clk, rst_n, m_axis_tvalid && !m_axis_tdata[PCT_W+2], (m_axis_tdata[PCT_W-1:0] == 7'd100) && !m_axis_tdata[PCT_W])

endmodule

bind battery_level_smoother_core bls_checker u_bls_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
